>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the image region table allocator.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

>>> hw/rtl/irta_pkg.sv
// Package of the image region table allocator: sizes, reset values, codes,
// the entry layout and the controller state type. Depends on nothing.
package irta_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int INDEX_W = 10;
    localparam int DIM_W = 16;
    localparam int PAGE_W = 16;
    localparam int LIMIT_W = 11;
    localparam int CFG_DATA_W = 16;
    localparam int BYTES_W = 32;

    localparam int PAGE_BYTES = 256;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam logic [PAGE_W-1:0] FIRST_PAGE_RESET = 16'd528;
    localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RESET = 11'd672;
    localparam logic [PAGE_W-1:0] REJECT_PAGE = 16'hFFFF;
    localparam logic [BYTES_W-1:0] PAGE_ROUND = BYTES_W'(PAGE_BYTES - 1);

    localparam logic CFG_FIRST_PAGE = 1'b0;
    localparam logic CFG_ENTRY_LIMIT = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [PAGE_W-1:0] start;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } entry_t;

    localparam entry_t ERASED_ENTRY = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/image_region_table_allocator.sv
// Top level of the image region table allocator: entry memory and its controller.
// Depends on irta_pkg and assert_macros.svh.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    operation, entry_index, width, height
// result    out        out_valid / out_ready  start_page, width_out, height_out, rejected
// config    in         cfg_wr_en              cfg_index, cfg_data
//
// One item is in work at a time. A lookup passes through the read and done states before the
// result register loads; an allocate through read, calc and done (read, multiply, page add,
// write-back); a rejected index or an allocate of entry zero goes straight to done.
// After reset a clearing pass writes the erased value into all 1024 entries, one per cycle,
// with in_ready low. A result waiting in the output register does not stop the next transfer;
// the item behind it holds in its last step until the output register is free.
`include "assert_macros.svh"

module image_region_table_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [irta_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [irta_pkg::INDEX_W-1:0]        entry_index,
    input  logic [irta_pkg::DIM_W-1:0]          width,
    input  logic [irta_pkg::DIM_W-1:0]          height,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [irta_pkg::PAGE_W-1:0]         start_page,
    output logic [irta_pkg::DIM_W-1:0]          width_out,
    output logic [irta_pkg::DIM_W-1:0]          height_out,
    output logic                                rejected
);

    irta_pkg::state_t state_reg, state_next;
    logic [irta_pkg::ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [irta_pkg::PAGE_W-1:0] first_page_reg;
    logic [irta_pkg::LIMIT_W-1:0] entry_limit_reg;

    logic op_reg, op_next;
    logic rej_reg, rej_next;
    logic [irta_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [irta_pkg::PAGE_W-1:0] start_reg, start_next;
    logic [irta_pkg::DIM_W-1:0] w_reg, w_next;
    logic [irta_pkg::DIM_W-1:0] h_reg, h_next;
    logic [irta_pkg::BYTES_W-1:0] prod_reg, prod_next;
    logic [irta_pkg::PAGE_W-1:0] pstart_reg, pstart_next;

    logic out_valid_reg, out_valid_next;
    logic [irta_pkg::PAGE_W-1:0] out_start_reg, out_start_next;
    logic [irta_pkg::DIM_W-1:0] out_w_reg, out_w_next;
    logic [irta_pkg::DIM_W-1:0] out_h_reg, out_h_next;
    logic out_rej_reg, out_rej_next;

    irta_pkg::entry_t mem [irta_pkg::TABLE_ENTRIES];
    irta_pkg::entry_t rdata_reg;
    irta_pkg::entry_t mem_wdata;
    logic mem_we;
    logic mem_re;
    logic [irta_pkg::ADDR_W-1:0] mem_waddr;
    logic [irta_pkg::ADDR_W-1:0] mem_raddr;

    logic in_xfer;
    logic in_reject;
    logic out_load;
    logic [irta_pkg::ADDR_W-1:0] in_addr;
    logic [irta_pkg::BYTES_W-1:0] bytes;
    logic [irta_pkg::BYTES_W-1:0] rounded;
    logic [irta_pkg::PAGE_W-1:0] pages;

    assign in_ready = (state_reg == irta_pkg::ST_IDLE);
    assign in_xfer = in_valid && in_ready;
    assign out_load = (state_reg == irta_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign in_addr = irta_pkg::ADDR_W'(entry_index);
    assign in_reject = (irta_pkg::LIMIT_W'(entry_index) >= entry_limit_reg)
        || (irta_pkg::CNT_W'(entry_index) >= irta_pkg::CNT_W'(irta_pkg::TABLE_ENTRIES));

    assign bytes = {prod_reg[irta_pkg::BYTES_W-2:0], 1'b0};
    assign rounded = bytes + irta_pkg::PAGE_ROUND;
    assign pages = irta_pkg::PAGE_W'(rounded >> irta_pkg::PAGE_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_page_reg <= irta_pkg::FIRST_PAGE_RESET;
            entry_limit_reg <= irta_pkg::ENTRY_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                irta_pkg::CFG_FIRST_PAGE:
                    first_page_reg <= cfg_data;
                irta_pkg::CFG_ENTRY_LIMIT:
                    entry_limit_reg <= irta_pkg::LIMIT_W'(cfg_data);
                default:
                    first_page_reg <= first_page_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= irta_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        rej_reg <= rej_next;
        addr_reg <= addr_next;
        start_reg <= start_next;
        w_reg <= w_next;
        h_reg <= h_next;
        prod_reg <= prod_next;
        pstart_reg <= pstart_next;
        out_start_reg <= out_start_next;
        out_w_reg <= out_w_next;
        out_h_reg <= out_h_next;
        out_rej_reg <= out_rej_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        op_next = op_reg;
        rej_next = rej_reg;
        addr_next = addr_reg;
        start_next = start_reg;
        w_next = w_reg;
        h_next = h_reg;
        prod_next = prod_reg;
        pstart_next = pstart_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_start_next = out_start_reg;
        out_w_next = out_w_reg;
        out_h_next = out_h_reg;
        out_rej_next = out_rej_reg;
        mem_we = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = {start_reg, w_reg, h_reg};
        mem_re = 1'b0;
        mem_raddr = in_addr;

        unique case (state_reg)
            irta_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = irta_pkg::ERASED_ENTRY;
                clr_cnt_next = clr_cnt_reg + irta_pkg::ADDR_W'(1);
                if (clr_cnt_reg == irta_pkg::ADDR_W'(irta_pkg::TABLE_ENTRIES - 1))
                begin
                    state_next = irta_pkg::ST_IDLE;
                end
            end
            irta_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next = operation;
                    rej_next = in_reject;
                    addr_next = in_addr;
                    w_next = width;
                    h_next = height;
                    if (in_reject)
                    begin
                        start_next = irta_pkg::REJECT_PAGE;
                        w_next = '0;
                        h_next = '0;
                        state_next = irta_pkg::ST_DONE;
                    end
                    else if (operation == irta_pkg::OP_LOOKUP)
                    begin
                        mem_re = 1'b1;
                        state_next = irta_pkg::ST_READ;
                    end
                    else if (entry_index == '0)
                    begin
                        start_next = first_page_reg;
                        state_next = irta_pkg::ST_DONE;
                    end
                    else
                    begin
                        mem_re = 1'b1;
                        mem_raddr = in_addr - irta_pkg::ADDR_W'(1);
                        state_next = irta_pkg::ST_READ;
                    end
                end
            end
            irta_pkg::ST_READ:
            begin
                if (op_reg == irta_pkg::OP_LOOKUP)
                begin
                    start_next = rdata_reg.start;
                    w_next = rdata_reg.width;
                    h_next = rdata_reg.height;
                    state_next = irta_pkg::ST_DONE;
                end
                else
                begin
                    prod_next = irta_pkg::BYTES_W'(rdata_reg.width)
                        * irta_pkg::BYTES_W'(rdata_reg.height);
                    pstart_next = rdata_reg.start;
                    state_next = irta_pkg::ST_CALC;
                end
            end
            irta_pkg::ST_CALC:
            begin
                start_next = pstart_reg + pages;
                state_next = irta_pkg::ST_DONE;
            end
            irta_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    mem_we = (op_reg == irta_pkg::OP_ALLOC) && !rej_reg;
                    out_valid_next = 1'b1;
                    out_start_next = start_reg;
                    out_w_next = w_reg;
                    out_h_next = h_reg;
                    out_rej_next = rej_reg;
                    state_next = irta_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = irta_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign start_page = out_start_reg;
    assign width_out = out_w_reg;
    assign height_out = out_h_reg;
    assign rejected = out_rej_reg;

    `ASSERT_IMPLY(a_write_only_on_alloc, clk, rst_n,
        mem_we && (state_reg != irta_pkg::ST_CLEAR),
        out_load && !rej_reg && (op_reg == irta_pkg::OP_ALLOC))
    `ASSERT_IMPLY(a_reject_payload, clk, rst_n, out_valid && rejected,
        (start_page == irta_pkg::REJECT_PAGE) && (width_out == '0) && (height_out == '0))
    `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_xfer, !in_ready)

endmodule
